>>> sv/bts_pkg.sv
package bts_pkg;

  localparam int unsigned TfW    = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned IdfW   = 21;
  localparam int unsigned K1W    = 16;
  localparam int unsigned BW     = 16;
  localparam int unsigned AvgW   = 24;
  localparam int unsigned ScoreW = 25;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned IdxW   = 2;

  // length-ratio divider: quotient T < 2^24, divisor avgdl
  localparam int unsigned Div1W  = 24;
  // score divider: 25 quotient bits, divisor D up to 33 bits
  localparam int unsigned Div2NW = 25;
  localparam int unsigned Div2DW = 33;

  localparam logic [BW-1:0]     BMax     = 16'd32768;
  localparam logic [AvgW-1:0]   AvgMin   = 24'd256;
  localparam logic [24:0]       OneQ16   = 25'd65536;
  localparam logic [16:0]       OneQ13   = 17'd8192;
  localparam logic [ScoreW-1:0] ScoreMax = 25'h1FFFFFF;

  localparam logic [IdfW-1:0] IdfReset = '0;
  localparam logic [K1W-1:0]  K1Reset  = 16'd9830;
  localparam logic [BW-1:0]   BReset   = 16'd24576;
  localparam logic [AvgW-1:0] AvgReset = 24'd256;

  typedef enum logic [IdxW-1:0] {
    REG_IDF = 2'd0,
    REG_K1  = 2'd1,
    REG_B   = 2'd2,
    REG_AVG = 2'd3
  } reg_idx_e;

endpackage

>>> sv/bts_div_cell.sv
// One restoring-division step: shifts in one dividend bit, emits one quotient bit.
module bts_div_cell
  import bts_pkg::*;
#(
  parameter int unsigned DW = 24,
  parameter int unsigned NW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic          v_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] nq_q, nq_d;
  logic [DW-1:0] den_q;
  logic [SW-1:0] side_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign v_o    = v_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

>>> sv/bts_out_buf.sv
// Output register plus one skid entry; the pipeline freezes only when both are full.
module bts_out_buf
  import bts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_v_i,
  input  logic [ScoreW-1:0] res_data_i,
  output logic              en_o,
  output logic              out_v_o,
  input  logic              out_rdy_i,
  output logic [ScoreW-1:0] out_data_o
);

  logic              ov_q, sv_q;
  logic [ScoreW-1:0] out_q, skid_q;
  logic              take;

  assign en_o = !sv_q;
  assign take = res_v_i && !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || out_rdy_i) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= take;
      end
    end else if (take) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_rdy_i) begin
      out_q <= sv_q ? skid_q : res_data_i;
    end else if (take) begin
      skid_q <= res_data_i;
    end
  end

  assign out_v_o    = ov_q;
  assign out_data_o = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid entry held while output empty");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && out_rdy_i) |=> (ov_q && !sv_q)) else $error("skid entry not moved");
  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && !out_rdy_i) |=> (sv_q && $stable(skid_q))) else $error("skid entry lost");

endmodule

>>> sv/bts_core.sv
// Arithmetic between the two divider chains: length norm, k1 product, numerator.
module bts_core
  import bts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  logic [Div1W-1:0]  t_i,
  input  logic [TfW-1:0]    tf_i,
  input  logic [BW-1:0]     bq_i,
  input  logic [K1W-1:0]    k1_i,
  input  logic [IdfW-1:0]   idf_i,
  output logic              v_o,
  output logic [53:0]       p_o,
  output logic [Div2DW-1:0] d_o,
  output logic              zero_o
);

  logic              b_v_q, c_v_q, d_v_q;
  logic [24:0]       b_len_q;
  logic [TfW-1:0]    b_tf_q, c_tf_q;
  logic [27:0]       c_k_q;
  logic [32:0]       c_n_q;
  logic              c_zero_q, d_zero_q;
  logic [53:0]       d_p_q;
  logic [Div2DW-1:0] d_d_q;
  logic [40:0]       kprod;

  assign kprod = 41'(k1_i) * 41'(b_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= v_i;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1 - b + b*dl/avgdl in Q.16
      b_len_q  <= OneQ16 - 25'({bq_i, 1'b0}) + 25'(t_i);
      b_tf_q   <= tf_i;
      c_k_q    <= kprod[40:13];
      c_n_q    <= 33'(b_tf_q) * 33'(17'(k1_i) + OneQ13);
      c_tf_q   <= b_tf_q;
      c_zero_q <= b_tf_q == '0;
      d_p_q    <= 54'(idf_i) * 54'(c_n_q);
      d_d_q    <= 33'({c_tf_q, 16'd0}) + 33'(c_k_q);
      d_zero_q <= c_zero_q;
    end
  end

  assign v_o    = d_v_q;
  assign p_o    = d_p_q;
  assign d_o    = d_d_q;
  assign zero_o = d_zero_q;

endmodule

>>> sv/bm25_term_score.sv
// BM25 term scorer. Each item is one posting (term_freq, norm_code); each yields one
// score = idf*tf*(k1+1)/(tf + k1*(1 - b + b*dl/avgdl)) in unsigned Q9.16, truncated
// and saturated to 2^25-1, and 0 whenever term_freq is 0. norm_code 0 means length 1.
// Throughput is one item per clock while the pipeline is not halted; its 53 register
// stages are 24 cells of the dl/avgdl divider, three arithmetic stages, 25 cells of the
// score divider and the output register. Each divider cell retires one quotient bit.
// An output register plus one skid entry let the input keep flowing while a result
// waits; the pipeline halts only when both are full. Registers are written via
// cfg_we_i/cfg_idx_i/cfg_wdata_i (0 idf Q5.16, 1 k1 Q3.13, 2 b Q1.15, 3 avgdl Q16.8)
// and should only change while no item is in flight. b above 1.0 is used as 1.0 and
// avgdl below 1.0 as 1.0.
module bm25_term_score
  import bts_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // [15:0] term_freq, [23:16] norm_code
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // [24:0] term_score, [31:25] zero
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  // configuration
  logic [IdfW-1:0] idf_q;
  logic [K1W-1:0]  k1_q;
  logic [BW-1:0]   b_q;
  logic [AvgW-1:0] avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idf_q <= IdfReset;
      k1_q  <= K1Reset;
      b_q   <= BReset;
      avg_q <= AvgReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IDF: idf_q <= cfg_wdata_i[IdfW-1:0];
        REG_K1:  k1_q  <= cfg_wdata_i[K1W-1:0];
        REG_B:   b_q   <= cfg_wdata_i[BW-1:0];
        REG_AVG: avg_q <= cfg_wdata_i[AvgW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign s_axis_tready = en;

  // front: clamp, decode length, form b*dl*2^9
  logic [TfW-1:0]   tf;
  logic [CodeW-1:0] dl;
  logic [BW-1:0]    bq;
  logic [AvgW-1:0]  avg;
  logic [23:0]      bdl;
  logic [31:0]      div1_num;

  always_comb begin
    tf       = s_axis_tdata[15:0];
    dl       = (s_axis_tdata[23:16] == '0) ? 8'd1 : s_axis_tdata[23:16];
    bq       = (b_q > BMax) ? BMax : b_q;
    avg      = (avg_q < AvgMin) ? AvgMin : avg_q;
    bdl      = 24'(bq) * 24'(dl);
    div1_num = {bdl[22:0], 9'd0};
  end

  // dl/avgdl divider chain; quotient fits 24 bits, so high byte preloads the remainder
  localparam int unsigned S1W = TfW + BW;
  logic             v1   [0:Div1W];
  logic [Div1W-1:0] rem1 [0:Div1W];
  logic [Div1W-1:0] nq1  [0:Div1W];
  logic [Div1W-1:0] den1 [0:Div1W];
  logic [S1W-1:0]   sd1  [0:Div1W];

  assign v1[0]   = s_axis_tvalid;
  assign rem1[0] = 24'(div1_num[31:24]);
  assign nq1[0]  = div1_num[23:0];
  assign den1[0] = avg;
  assign sd1[0]  = {bq, tf};

  for (genvar i = 0; i < Div1W; i++) begin : g_div1
    bts_div_cell #(.DW(Div1W), .NW(Div1W), .SW(S1W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .v_i(v1[i]), .rem_i(rem1[i]), .nq_i(nq1[i]), .den_i(den1[i]), .side_i(sd1[i]),
      .v_o(v1[i+1]), .rem_o(rem1[i+1]), .nq_o(nq1[i+1]), .den_o(den1[i+1]),
      .side_o(sd1[i+1])
    );
  end

  // middle arithmetic
  logic              cv;
  logic [53:0]       cp;
  logic [Div2DW-1:0] cd;
  logic              czero;

  bts_core u_core (
    .clk_i, .rst_ni, .en_i(en),
    .v_i(v1[Div1W]), .t_i(nq1[Div1W]),
    .tf_i(sd1[Div1W][TfW-1:0]), .bq_i(sd1[Div1W][S1W-1:TfW]),
    .k1_i(k1_q), .idf_i(idf_q),
    .v_o(cv), .p_o(cp), .d_o(cd), .zero_o(czero)
  );

  // score divider: idf*N*8 / D; top bits against D decide saturation up front
  logic [56:0] div2_num;
  logic [32:0] hi;
  logic        sat;

  always_comb begin
    div2_num = {cp, 3'd0};
    hi       = {1'b0, div2_num[56:25]};
    sat      = hi >= cd;
  end

  logic              v2   [0:Div2NW];
  logic [Div2DW-1:0] rem2 [0:Div2NW];
  logic [Div2NW-1:0] nq2  [0:Div2NW];
  logic [Div2DW-1:0] den2 [0:Div2NW];
  logic [1:0]        sd2  [0:Div2NW];

  assign v2[0]   = cv;
  assign rem2[0] = sat ? '0 : hi;
  assign nq2[0]  = div2_num[24:0];
  assign den2[0] = cd;
  assign sd2[0]  = {czero, sat};

  for (genvar j = 0; j < Div2NW; j++) begin : g_div2
    bts_div_cell #(.DW(Div2DW), .NW(Div2NW), .SW(2)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .v_i(v2[j]), .rem_i(rem2[j]), .nq_i(nq2[j]), .den_i(den2[j]), .side_i(sd2[j]),
      .v_o(v2[j+1]), .rem_o(rem2[j+1]), .nq_o(nq2[j+1]), .den_o(den2[j+1]),
      .side_o(sd2[j+1])
    );
  end

  logic [ScoreW-1:0] score;
  always_comb begin
    if (sd2[Div2NW][1]) begin
      score = '0;
    end else if (sd2[Div2NW][0]) begin
      score = ScoreMax;
    end else begin
      score = nq2[Div2NW];
    end
  end

  logic [ScoreW-1:0] out_data;

  bts_out_buf u_out (
    .clk_i, .rst_ni,
    .res_v_i(v2[Div2NW]), .res_data_i(score),
    .en_o(en),
    .out_v_o(m_axis_tvalid), .out_rdy_i(m_axis_tready), .out_data_o(out_data)
  );

  assign m_axis_tdata = {7'd0, out_data};

endmodule
